### rtl/qrs_pkg.sv
`timescale 1ns / 1ps

package qrs_pkg;

    typedef struct packed
    {
        logic en;
        logic valid;
    } qrs_step_t;

    localparam int ADDR_W = 3;
    localparam int REG_IDX_W = ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_BAND = '0;
    localparam logic [31:0] BAND_RESET = 32'd4295;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic [1:0] CNT_INF  = 2'd3;

endpackage

### rtl/qrs_sqrt_cell.sv
`timescale 1ns / 1ps

module qrs_sqrt_cell
    import qrs_pkg::*;
#(
    parameter int SW   = 33,
    parameter int CTXW = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  qrs_step_t         step,
    input  logic [2*SW-1:0]   rad_in,
    input  logic [SW+1:0]     rem_in,
    input  logic [SW-1:0]     root_in,
    input  logic [CTXW-1:0]   ctx_in,
    output logic              valid_out,
    output logic [2*SW-1:0]   rad_out,
    output logic [SW+1:0]     rem_out,
    output logic [SW-1:0]     root_out,
    output logic [CTXW-1:0]   ctx_out
);

    logic [SW+3:0]   wide;
    logic [SW+3:0]   trial;
    logic [SW+3:0]   diff;
    logic            fits;
    logic [2*SW-1:0] rad_next;
    logic [SW+1:0]   rem_next;
    logic [SW-1:0]   root_next;

    logic            valid_reg;
    logic [2*SW-1:0] rad_reg;
    logic [SW+1:0]   rem_reg;
    logic [SW-1:0]   root_reg;
    logic [CTXW-1:0] ctx_reg;

    always_comb
    begin
        wide      = {rem_in, rad_in[2*SW-1 -: 2]};
        trial     = {2'b00, root_in, 2'b01};
        fits      = (wide >= trial);
        diff      = wide - trial;
        rem_next  = fits ? diff[SW+1:0] : wide[SW+1:0];
        root_next = {root_in[SW-2:0], fits};
        rad_next  = {rad_in[2*SW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step.en)
        begin
            valid_reg <= step.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            ctx_reg  <= ctx_in;
        end
    end

    assign valid_out = valid_reg;
    assign rad_out   = rad_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign ctx_out   = ctx_reg;

endmodule

### rtl/qrs_div_cell.sv
`timescale 1ns / 1ps

module qrs_div_cell
    import qrs_pkg::*;
#(
    parameter int QW   = 49,
    parameter int DVW  = 33,
    parameter int CTXW = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  qrs_step_t         step,
    input  logic [QW-1:0]     work_in,
    input  logic [DVW-1:0]    rem_in,
    input  logic [DVW-1:0]    den_in,
    input  logic [CTXW-1:0]   ctx_in,
    output logic              valid_out,
    output logic [QW-1:0]     work_out,
    output logic [DVW-1:0]    rem_out,
    output logic [DVW-1:0]    den_out,
    output logic [CTXW-1:0]   ctx_out
);

    logic [DVW:0]    wide;
    logic [DVW:0]    diff;
    logic            fits;
    logic [QW-1:0]   work_next;
    logic [DVW-1:0]  rem_next;

    logic            valid_reg;
    logic [QW-1:0]   work_reg;
    logic [DVW-1:0]  rem_reg;
    logic [DVW-1:0]  den_reg;
    logic [CTXW-1:0] ctx_reg;

    always_comb
    begin
        wide      = {rem_in, work_in[QW-1]};
        fits      = (wide >= {1'b0, den_in});
        diff      = wide - {1'b0, den_in};
        rem_next  = fits ? diff[DVW-1:0] : wide[DVW-1:0];
        work_next = {work_in[QW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (step.en)
        begin
            valid_reg <= step.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.en)
        begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
            den_reg  <= den_in;
            ctx_reg  <= ctx_in;
        end
    end

    assign valid_out = valid_reg;
    assign work_out  = work_reg;
    assign rem_out   = rem_reg;
    assign den_out   = den_reg;
    assign ctx_out   = ctx_reg;

endmodule

### rtl/quadratic_root_solver.sv
`timescale 1ns / 1ps

// Solves a*x^2 + b*x + c = 0 for signed fixed-point coefficients and returns the
// root count, up to two roots and a saturation flag for every input word. A new
// word is taken every cycle while s_tready is high, which drops once the output
// buffer is full. A row of COEF_WIDTH+1 square-root cells computes one root
// bit per cell, followed by two parallel rows of COEF_WIDTH+1+FRAC_BITS divider
// cells, one quotient bit per cell. A two-word output buffer lets the input keep
// flowing while a result waits. near_zero_band sits at byte address 0 and must
// only be written while no word is in flight.

module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COEF_WIDTH = 32
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [95:0]       s_tdata,   // coef_a, coef_b, coef_c
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [71:0]       m_tdata,   // root_count, root_one, root_two, overflow, pad
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int CW   = COEF_WIDTH;
    localparam int PW   = 2 * CW;
    localparam int TW   = 2 * CW + 3;
    localparam int SW   = CW + 1;
    localparam int RW   = 2 * SW;
    localparam int NW   = CW + 2;
    localparam int DVW  = CW + 1;
    localparam int QW   = CW + 1 + FRAC_BITS;
    localparam int SCW  = 5 + 3 * CW;
    localparam int DCW  = 5;
    localparam logic [QW-1:0] LIM_POS = QW'((64'd1 << (CW - 1)) - 64'd1);

    logic        en;
    logic [31:0] band_reg;
    logic [31:0] tol32;

    assign pready = 1'b1;
    assign tol32  = band_reg >> FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg <= BAND_RESET;
        end
        else if (psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_BAND))
        begin
            band_reg <= pwdata;
        end
    end

    assign prdata = (paddr[ADDR_W-1:2] == REG_BAND) ? band_reg : 32'd0;

    // stage 1: capture
    logic          v1_reg;
    logic [CW-1:0] a1_reg, b1_reg, c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg <= s_tdata[CW-1:0];
            b1_reg <= s_tdata[32+CW-1:32];
            c1_reg <= s_tdata[64+CW-1:64];
        end
    end

    // stage 2: magnitudes and near-zero tests
    logic [CW-1:0] ua_next, ub_next, uc_next;
    logic          v2_reg, sa2_reg, sc2_reg, na2_reg, nb2_reg, nc2_reg;
    logic [CW-1:0] ua2_reg, ub2_reg, uc2_reg, b2_reg, c2_reg;

    always_comb
    begin
        ua_next = a1_reg[CW-1] ? (CW'(0) - a1_reg) : a1_reg;
        ub_next = b1_reg[CW-1] ? (CW'(0) - b1_reg) : b1_reg;
        uc_next = c1_reg[CW-1] ? (CW'(0) - c1_reg) : c1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ua2_reg <= ua_next;
            ub2_reg <= ub_next;
            uc2_reg <= uc_next;
            b2_reg  <= b1_reg;
            c2_reg  <= c1_reg;
            sa2_reg <= a1_reg[CW-1];
            sc2_reg <= c1_reg[CW-1];
            na2_reg <= (32'(ua_next) <= tol32);
            nb2_reg <= (32'(ub_next) <= tol32);
            nc2_reg <= (32'(uc_next) <= tol32);
        end
    end

    // stage 3: products
    logic          v3_reg, mix3_reg, sa3_reg, na3_reg, nb3_reg, nc3_reg;
    logic [PW-1:0] bb3_reg, ac3_reg;
    logic [CW-1:0] ua3_reg, b3_reg, c3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            bb3_reg  <= PW'(ub2_reg) * PW'(ub2_reg);
            ac3_reg  <= PW'(ua2_reg) * PW'(uc2_reg);
            mix3_reg <= sa2_reg ^ sc2_reg;
            ua3_reg  <= ua2_reg;
            b3_reg   <= b2_reg;
            c3_reg   <= c2_reg;
            sa3_reg  <= sa2_reg;
            na3_reg  <= na2_reg;
            nb3_reg  <= nb2_reg;
            nc3_reg  <= nc2_reg;
        end
    end

    // stage 4: discriminant
    logic [TW-1:0] t_next;
    logic          v4_reg, sa4_reg, na4_reg, nb4_reg, nc4_reg;
    logic [TW-1:0] t4_reg;
    logic [CW-1:0] ua4_reg, b4_reg, c4_reg;

    always_comb
    begin
        if (mix3_reg)
            t_next = TW'(bb3_reg) + TW'({ac3_reg, 2'b00});
        else
            t_next = TW'(bb3_reg) - TW'({ac3_reg, 2'b00});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t4_reg  <= t_next;
            ua4_reg <= ua3_reg;
            b4_reg  <= b3_reg;
            c4_reg  <= c3_reg;
            sa4_reg <= sa3_reg;
            na4_reg <= na3_reg;
            nb4_reg <= nb3_reg;
            nc4_reg <= nc3_reg;
        end
    end

    // stage 5: classify
    logic          dneg, dnear, two_next;
    logic [TW-1:0] dmag;
    logic [1:0]    cnt_next;
    logic          v5_reg;
    logic [RW-1:0] rad5_reg;
    logic [SCW-1:0] sctx5_reg;

    always_comb
    begin
        dneg  = t4_reg[TW-1];
        dmag  = dneg ? (TW'(0) - t4_reg) : t4_reg;
        dnear = (dmag <= TW'(band_reg));
        two_next = 1'b0;
        if (na4_reg)
        begin
            if (nb4_reg)
                cnt_next = nc4_reg ? CNT_INF : CNT_NONE;
            else
                cnt_next = CNT_ONE;
        end
        else if (dnear)
        begin
            cnt_next = CNT_ONE;
        end
        else if (dneg)
        begin
            cnt_next = CNT_NONE;
        end
        else
        begin
            cnt_next = CNT_TWO;
            two_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v5_reg <= 1'b0;
        else if (en)
            v5_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad5_reg  <= dmag[RW-1:0];
            sctx5_reg <= {cnt_next, two_next, na4_reg, sa4_reg, b4_reg, c4_reg, ua4_reg};
        end
    end

    // square-root row
    logic            sq_valid [0:SW];
    logic [RW-1:0]   sq_rad   [0:SW];
    logic [SW+1:0]   sq_rem   [0:SW];
    logic [SW-1:0]   sq_root  [0:SW];
    logic [SCW-1:0]  sq_ctx   [0:SW];

    assign sq_valid[0] = v5_reg;
    assign sq_rad[0]   = rad5_reg;
    assign sq_rem[0]   = '0;
    assign sq_root[0]  = '0;
    assign sq_ctx[0]   = sctx5_reg;

    for (genvar i = 0; i < SW; i++)
    begin : g_sqrt
        qrs_sqrt_cell #(.SW(SW), .CTXW(SCW)) u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      ('{en: en, valid: sq_valid[i]}),
            .rad_in    (sq_rad[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .ctx_in    (sq_ctx[i]),
            .valid_out (sq_valid[i+1]),
            .rad_out   (sq_rad[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .ctx_out   (sq_ctx[i+1])
        );
    end

    // stage 6: numerators and divisors
    logic [1:0]    s_cnt;
    logic          s_two, s_lin, s_sa;
    logic [CW-1:0] s_b, s_c, s_ua, bmag;
    logic [SW-1:0] s_eff;
    logic [NW-1:0] bx, cx, sx;
    logic          v6_reg, dn1_6_reg, sa6_reg, lin6_reg, two6_reg;
    logic [1:0]    cnt6_reg;
    logic [NW-1:0] n1_6_reg, n2_6_reg;
    logic [DVW-1:0] d1_6_reg, d2_6_reg;

    always_comb
    begin
        {s_cnt, s_two, s_lin, s_sa, s_b, s_c, s_ua} = sq_ctx[SW];
        s_eff = s_two ? sq_root[SW] : '0;
        bx    = {{2{s_b[CW-1]}}, s_b};
        cx    = {{2{s_c[CW-1]}}, s_c};
        sx    = {1'b0, s_eff};
        bmag  = s_b[CW-1] ? (CW'(0) - s_b) : s_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v6_reg <= 1'b0;
        else if (en)
            v6_reg <= sq_valid[SW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_6_reg  <= s_lin ? (NW'(0) - cx) : (sx - bx);
            n2_6_reg  <= NW'(0) - bx - sx;
            d1_6_reg  <= s_lin ? {1'b0, bmag} : {s_ua, 1'b0};
            d2_6_reg  <= {s_ua, 1'b0};
            dn1_6_reg <= s_lin ? s_b[CW-1] : s_sa;
            sa6_reg   <= s_sa;
            lin6_reg  <= s_lin;
            two6_reg  <= s_two;
            cnt6_reg  <= s_cnt;
        end
    end

    // stage 7: dividend magnitudes
    logic [NW-1:0] m1, m2;
    logic          v7_reg;
    logic [QW-1:0] w1_7_reg, w2_7_reg;
    logic [DVW-1:0] d1_7_reg, d2_7_reg;
    logic [DCW-1:0] ctx7_reg;
    logic          neg2_7_reg;

    always_comb
    begin
        m1 = n1_6_reg[NW-1] ? (NW'(0) - n1_6_reg) : n1_6_reg;
        m2 = n2_6_reg[NW-1] ? (NW'(0) - n2_6_reg) : n2_6_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v7_reg <= 1'b0;
        else if (en)
            v7_reg <= v6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w1_7_reg   <= {m1[CW:0], {FRAC_BITS{1'b0}}};
            w2_7_reg   <= {m2[CW:0], {FRAC_BITS{1'b0}}};
            d1_7_reg   <= d1_6_reg;
            d2_7_reg   <= d2_6_reg;
            ctx7_reg   <= {cnt6_reg, two6_reg, lin6_reg, n1_6_reg[NW-1] ^ dn1_6_reg};
            neg2_7_reg <= n2_6_reg[NW-1] ^ sa6_reg;
        end
    end

    // divider rows
    logic            dv1_valid [0:QW];
    logic [QW-1:0]   dv1_work  [0:QW];
    logic [DVW-1:0]  dv1_rem   [0:QW];
    logic [DVW-1:0]  dv1_den   [0:QW];
    logic [DCW-1:0]  dv1_ctx   [0:QW];
    logic            dv2_valid [0:QW];
    logic [QW-1:0]   dv2_work  [0:QW];
    logic [DVW-1:0]  dv2_rem   [0:QW];
    logic [DVW-1:0]  dv2_den   [0:QW];
    logic [0:0]      dv2_ctx   [0:QW];

    assign dv1_valid[0] = v7_reg;
    assign dv1_work[0]  = w1_7_reg;
    assign dv1_rem[0]   = '0;
    assign dv1_den[0]   = d1_7_reg;
    assign dv1_ctx[0]   = ctx7_reg;
    assign dv2_valid[0] = v7_reg;
    assign dv2_work[0]  = w2_7_reg;
    assign dv2_rem[0]   = '0;
    assign dv2_den[0]   = d2_7_reg;
    assign dv2_ctx[0]   = neg2_7_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        qrs_div_cell #(.QW(QW), .DVW(DVW), .CTXW(DCW)) u_cell_one
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      ('{en: en, valid: dv1_valid[i]}),
            .work_in   (dv1_work[i]),
            .rem_in    (dv1_rem[i]),
            .den_in    (dv1_den[i]),
            .ctx_in    (dv1_ctx[i]),
            .valid_out (dv1_valid[i+1]),
            .work_out  (dv1_work[i+1]),
            .rem_out   (dv1_rem[i+1]),
            .den_out   (dv1_den[i+1]),
            .ctx_out   (dv1_ctx[i+1])
        );

        qrs_div_cell #(.QW(QW), .DVW(DVW), .CTXW(1)) u_cell_two
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      ('{en: en, valid: dv2_valid[i]}),
            .work_in   (dv2_work[i]),
            .rem_in    (dv2_rem[i]),
            .den_in    (dv2_den[i]),
            .ctx_in    (dv2_ctx[i]),
            .valid_out (dv2_valid[i+1]),
            .work_out  (dv2_work[i+1]),
            .rem_out   (dv2_rem[i+1]),
            .den_out   (dv2_den[i+1]),
            .ctx_out   (dv2_ctx[i+1])
        );
    end

    // stage 8: snap and clamp
    logic [QW-1:0] q1, q2, tolq, lim1, lim2;
    logic [1:0]    f_cnt;
    logic          f_two, f_lin, f_neg1, f_neg2, snap1, gt1, gt2;
    logic          v8_reg, ov1_8_reg, ov2_8_reg, neg1_8_reg, neg2_8_reg;
    logic [1:0]    cnt8_reg;
    logic [CW-1:0] qc1_8_reg, qc2_8_reg;

    always_comb
    begin
        {f_cnt, f_two, f_lin, f_neg1} = dv1_ctx[QW];
        f_neg2 = dv2_ctx[QW][0];
        q1     = dv1_work[QW];
        q2     = dv2_work[QW];
        tolq   = QW'(tol32);
        lim1   = LIM_POS + QW'(f_neg1);
        lim2   = LIM_POS + QW'(f_neg2);
        snap1  = f_lin && (q1 <= tolq);
        gt1    = (q1 > lim1);
        gt2    = (q2 > lim2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v8_reg <= 1'b0;
        else if (en)
            v8_reg <= dv1_valid[QW] & dv2_valid[QW];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qc1_8_reg  <= snap1 ? '0 : (gt1 ? lim1[CW-1:0] : q1[CW-1:0]);
            qc2_8_reg  <= gt2 ? lim2[CW-1:0] : q2[CW-1:0];
            ov1_8_reg  <= !snap1 && gt1;
            ov2_8_reg  <= gt2 && f_two;
            neg1_8_reg <= f_neg1;
            neg2_8_reg <= f_neg2;
            cnt8_reg   <= f_cnt;
        end
    end

    // output word
    logic [CW-1:0] r1, r2;
    logic [31:0]   root_one, root_two;
    logic          has_one, has_two, ovf;
    logic [71:0]   word;

    always_comb
    begin
        r1       = neg1_8_reg ? (CW'(0) - qc1_8_reg) : qc1_8_reg;
        r2       = neg2_8_reg ? (CW'(0) - qc2_8_reg) : qc2_8_reg;
        has_one  = (cnt8_reg == CNT_ONE) || (cnt8_reg == CNT_TWO);
        has_two  = (cnt8_reg == CNT_TWO);
        root_one = has_one ? 32'($signed(r1)) : 32'd0;
        root_two = has_two ? 32'($signed(r2)) : 32'd0;
        ovf      = (has_one && ov1_8_reg) || (has_two && ov2_8_reg);
        word     = {5'b00000, ovf, root_two, root_one, cnt8_reg};
    end

    logic        out_valid_reg, skid_valid_reg;
    logic [71:0] out_data_reg, skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= v8_reg;
        end
        else if (v8_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
                out_data_reg <= skid_data_reg;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_data_reg <= word;
        end
        else
        begin
            skid_data_reg <= word;
        end
    end

endmodule
